// File: rtl/plb_pkg.sv
// shared types, codes and helpers for the pulse and blink output block
`timescale 1ns / 1ps
`default_nettype none

package plb_pkg;

  // width of every time and period count
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 32;

  // input and output transaction field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned IN_DATA_W = 136;
  localparam int unsigned OUT_DATA_W = 8;

  // operation codes carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_SET   = 3'd1,
    OP_PULSE = 3'd2,
    OP_BLINK = 3'd3,
    OP_ABORT = 3'd4
  } op_t;

  // output actions
  typedef enum logic [ACT_W-1:0] {
    ACT_RESET   = 2'd0,
    ACT_SET     = 2'd1,
    ACT_TOGGLE  = 2'd2,
    ACT_INVALID = 2'd3
  } act_t;

  // sequence kinds
  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_PULSE  = 2'd1,
    MODE_BLINK  = 2'd2
  } mode_t;

  // one result transaction
  typedef struct packed {
    logic status;
    logic busy_res;
    logic logic_level;
    logic pin_level;
  } plb_res_t;

  // new logical level after an action
  function automatic logic apply_act(input act_t act, input logic cur);
    logic lvl;
    lvl = cur;
    unique case (act)
      ACT_RESET:  lvl = 1'b0;
      ACT_SET:    lvl = 1'b1;
      ACT_TOGGLE: lvl = ~cur;
      default:    lvl = cur;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: rtl/plb_core.sv
// sequence state and per-transaction update of the pulse and blink block
`timescale 1ns / 1ps
`default_nettype none

module plb_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  input  wire logic                          acc,
  input  wire plb_pkg::op_t                  op,
  input  wire plb_pkg::act_t                 act,
  input  wire logic [plb_pkg::TIME_W-1:0]    delay_ticks,
  input  wire logic [plb_pkg::TIME_W-1:0]    active_ticks,
  input  wire logic [plb_pkg::TIME_W-1:0]    inactive_ticks,
  input  wire logic [plb_pkg::COUNT_W-1:0]   blink_count,
  output plb_pkg::plb_res_t                  res
);

  logic                           ah_r;
  logic                           logic_r, logic_nxt;
  logic                           remem_r, remem_nxt;
  plb_pkg::act_t                  pend_r, pend_nxt;
  plb_pkg::mode_t                 mode_r, mode_nxt;
  logic [plb_pkg::TIME_W-1:0]     delay_r, delay_nxt;
  logic [plb_pkg::TIME_W-1:0]     tick_r, tick_nxt;
  logic [plb_pkg::TIME_W-1:0]     alen_r, alen_nxt;
  logic [plb_pkg::TIME_W-1:0]     ilen_r, ilen_nxt;
  logic [plb_pkg::COUNT_W-1:0]    per_r, per_nxt;
  logic                           endless_r, endless_nxt;
  logic                           first_r, first_nxt;
  logic                           phase_r, phase_nxt;
  logic                           idle_r, idle_nxt;
  logic                           status;
  logic                           is_start;

  // launch request fields
  logic                           do_launch;
  logic                           do_return;
  logic                           flip;
  plb_pkg::mode_t                 l_mode;
  logic [plb_pkg::TIME_W-1:0]     l_alen;
  logic [plb_pkg::TIME_W-1:0]     l_ilen;
  logic [plb_pkg::COUNT_W-1:0]    l_cnt;

  assign is_start = (op == plb_pkg::OP_SET) || (op == plb_pkg::OP_PULSE) ||
                    (op == plb_pkg::OP_BLINK);

  // next state for one transaction
  always_comb begin
    logic_nxt   = logic_r;
    remem_nxt   = remem_r;
    pend_nxt    = pend_r;
    mode_nxt    = mode_r;
    delay_nxt   = delay_r;
    tick_nxt    = tick_r;
    alen_nxt    = alen_r;
    ilen_nxt    = ilen_r;
    per_nxt     = per_r;
    endless_nxt = endless_r;
    first_nxt   = first_r;
    phase_nxt   = phase_r;
    idle_nxt    = idle_r;
    status      = 1'b0;
    do_launch   = 1'b0;
    do_return   = 1'b0;
    flip        = 1'b0;
    l_mode      = plb_pkg::MODE_STATIC;
    l_alen      = '0;
    l_ilen      = '0;
    l_cnt       = '0;

    unique case (op)
      plb_pkg::OP_TICK: begin
        if (!idle_r) begin
          // saturating tick counter
          if (tick_r != {plb_pkg::TIME_W{1'b1}}) begin
            tick_nxt = tick_r + 1'b1;
          end
          if ((delay_r == '0) || (tick_nxt > delay_r)) begin
            delay_nxt = '0;
            unique case (mode_r)
              plb_pkg::MODE_PULSE: begin
                if (first_r) begin
                  logic_nxt = plb_pkg::apply_act(pend_r, logic_r);
                  first_nxt = 1'b0;
                  tick_nxt  = '0;
                end
                if (tick_nxt > alen_r) begin
                  do_return = 1'b1;
                end
              end
              plb_pkg::MODE_BLINK: begin
                if (first_r) begin
                  logic_nxt = plb_pkg::apply_act(pend_r, logic_r);
                  pend_nxt  = plb_pkg::ACT_TOGGLE;
                  first_nxt = 1'b0;
                  tick_nxt  = '0;
                end
                // phase end, count down periods at the end of each inactive phase
                if (phase_r && (tick_nxt > alen_r)) begin
                  flip = 1'b1;
                end else if (!phase_r && (tick_nxt > ilen_r)) begin
                  if (!endless_r) begin
                    per_nxt = per_r - 1'b1;
                    if (per_nxt == '0) begin
                      do_return = 1'b1;
                    end
                  end
                  flip = !do_return;
                end
                if (flip) begin
                  logic_nxt = plb_pkg::apply_act(pend_nxt, logic_nxt);
                  phase_nxt = ~phase_r;
                  tick_nxt  = '0;
                end
              end
              plb_pkg::MODE_STATIC: begin
                logic_nxt = plb_pkg::apply_act(pend_r, logic_r);
                remem_nxt = logic_nxt;
                idle_nxt  = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      plb_pkg::OP_SET, plb_pkg::OP_PULSE, plb_pkg::OP_BLINK: begin
        if (act == plb_pkg::ACT_INVALID) begin
          status = 1'b1;
        end else begin
          do_launch = 1'b1;
          unique case (op)
            plb_pkg::OP_PULSE: begin
              l_mode = plb_pkg::MODE_PULSE;
              l_alen = active_ticks;
            end
            plb_pkg::OP_BLINK: begin
              l_mode = plb_pkg::MODE_BLINK;
              l_alen = active_ticks;
              l_ilen = inactive_ticks;
              l_cnt  = blink_count;
            end
            default: begin
              l_mode = plb_pkg::MODE_STATIC;
            end
          endcase
        end
      end
      plb_pkg::OP_ABORT: begin
        // return to the remembered level on the next tick
        if (!idle_r) begin
          mode_nxt    = plb_pkg::MODE_STATIC;
          pend_nxt    = plb_pkg::act_t'({1'b0, remem_r});
          delay_nxt   = '0;
          tick_nxt    = '0;
          alen_nxt    = '0;
          ilen_nxt    = '0;
          per_nxt     = '0;
          endless_nxt = 1'b1;
          first_nxt   = 1'b1;
          phase_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // start a new sequence, replacing any running one
    if (do_launch) begin
      mode_nxt    = l_mode;
      pend_nxt    = act;
      delay_nxt   = delay_ticks;
      tick_nxt    = '0;
      alen_nxt    = l_alen;
      ilen_nxt    = l_ilen;
      per_nxt     = l_cnt;
      endless_nxt = (l_cnt == '0);
      first_nxt   = 1'b1;
      phase_nxt   = 1'b1;
      idle_nxt    = 1'b0;
    end

    // sequence done: restore the remembered level and go idle
    if (do_return) begin
      logic_nxt   = remem_r;
      mode_nxt    = plb_pkg::MODE_STATIC;
      pend_nxt    = plb_pkg::act_t'({1'b0, remem_r});
      delay_nxt   = '0;
      tick_nxt    = '0;
      alen_nxt    = '0;
      ilen_nxt    = '0;
      per_nxt     = '0;
      endless_nxt = 1'b1;
      first_nxt   = 1'b1;
      phase_nxt   = 1'b1;
      idle_nxt    = 1'b1;
    end
  end

  // result of this transaction
  assign res.pin_level   = logic_nxt ^ ~ah_r;
  assign res.logic_level = logic_nxt;
  assign res.busy_res    = ~idle_nxt;
  assign res.status      = status;

  // polarity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ah_r <= 1'b1;
    end else if (cfg_wr_en) begin
      ah_r <= cfg_wr_data;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logic_r   <= 1'b0;
      remem_r   <= 1'b0;
      pend_r    <= plb_pkg::ACT_RESET;
      mode_r    <= plb_pkg::MODE_STATIC;
      delay_r   <= '0;
      tick_r    <= '0;
      alen_r    <= '0;
      ilen_r    <= '0;
      per_r     <= '0;
      endless_r <= 1'b0;
      first_r   <= 1'b0;
      phase_r   <= 1'b0;
      idle_r    <= 1'b1;
    end else if (acc) begin
      logic_r   <= logic_nxt;
      remem_r   <= remem_nxt;
      pend_r    <= pend_nxt;
      mode_r    <= mode_nxt;
      delay_r   <= delay_nxt;
      tick_r    <= tick_nxt;
      alen_r    <= alen_nxt;
      ilen_r    <= ilen_nxt;
      per_r     <= per_nxt;
      endless_r <= endless_nxt;
      first_r   <= first_nxt;
      phase_r   <= phase_nxt;
      idle_r    <= idle_nxt;
    end
  end

`ifndef SYNTHESIS
  // only an accepted valid start leaves the idle state
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (idle_r && !(acc && is_start && (act != plb_pkg::ACT_INVALID))) |=> idle_r)
    else $error("idle left without a start");

  // a rejected start changes neither level nor sequence
  a_invalid_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_start && (act == plb_pkg::ACT_INVALID)) |=>
      ($stable(logic_r) && $stable(idle_r) && $stable(mode_r)))
    else $error("invalid action changed state");

  // a running blink train toggles once its first step is done
  a_blink_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (!idle_r && (mode_r == plb_pkg::MODE_BLINK) && !first_r) |->
      (pend_r == plb_pkg::ACT_TOGGLE))
    else $error("blink running without toggle action");

  // ticks while idle leave the level alone
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && idle_r && (op == plb_pkg::OP_TICK)) |=> $stable(logic_r))
    else $error("idle tick changed level");
`endif

endmodule

`default_nettype wire

// File: rtl/plb_out.sv
// result register and flow control between the two channels
`timescale 1ns / 1ps
`default_nettype none

module plb_out (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire plb_pkg::plb_res_t                 res,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [plb_pkg::OUT_DATA_W-1:0]         out_tdata
);

  logic                  valid_r;
  plb_pkg::plb_res_t     res_r;

  // take a new transaction whenever the result slot is free or draining
  assign in_tready  = ~valid_r | out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(plb_pkg::OUT_DATA_W - 4){1'b0}}, res_r};

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/logic_pulse_blink_output.sv
// Pulse and blink output generator, top level
//
// One logical output driven by commands and tick transactions on the in_
// channel. Opcode travels in in_tuser; the times and count in in_tdata.
// A set, pulse or blink command starts a sequence after a delay counted in
// ticks; tick transactions advance it. A blink count of zero runs endless
// until abort. Abort returns the output to its remembered level on the
// next tick.
// Every accepted transaction gives exactly one result transaction on out_
// with pin level, logical level, busy flag and status.
// out_tvalid rises in the cycle after acceptance; one transaction is
// accepted every cycle while the receiver takes results. The whole update
// is one pass of compare and add logic ahead of the result register.
// When the receiver stalls, the pending result is held and in_tready drops
// until it is taken.
// Reset clears the sequence, sets the output low and idle, and sets
// active-high polarity. cfg_wr_en writes the polarity bit.
`timescale 1ns / 1ps
`default_nettype none

module logic_pulse_blink_output (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_wr_data,   // active_high
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // action[1:0], delay_ticks[33:2], active_ticks[65:34],
  // inactive_ticks[97:66], blink_count[129:98], zero fill
  input  wire logic [plb_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [plb_pkg::OP_W-1:0]           in_tuser,      // opcode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // pin_level[0], logic_level[1], busy_res[2], status[3], zero fill
  output logic [plb_pkg::OUT_DATA_W-1:0]          out_tdata
);

  localparam int unsigned DLY_LO = plb_pkg::ACT_W;
  localparam int unsigned ACT_LO = DLY_LO + plb_pkg::TIME_W;
  localparam int unsigned INA_LO = ACT_LO + plb_pkg::TIME_W;
  localparam int unsigned CNT_LO = INA_LO + plb_pkg::TIME_W;

  logic               acc;
  plb_pkg::plb_res_t  res;

  assign acc = in_tvalid & in_tready;

  // sequence state and update
  plb_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .acc            (acc),
    .op             (plb_pkg::op_t'(in_tuser)),
    .act            (plb_pkg::act_t'(in_tdata[plb_pkg::ACT_W-1:0])),
    .delay_ticks    (in_tdata[DLY_LO +: plb_pkg::TIME_W]),
    .active_ticks   (in_tdata[ACT_LO +: plb_pkg::TIME_W]),
    .inactive_ticks (in_tdata[INA_LO +: plb_pkg::TIME_W]),
    .blink_count    (in_tdata[CNT_LO +: plb_pkg::COUNT_W]),
    .res            (res)
  );

  // result register
  plb_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: test/tb_logic_pulse_blink_output.sv
// testbench for the pulse and blink output generator: random commands and ticks, scoreboard check
`timescale 1ns / 1ps

module tb_logic_pulse_blink_output;
  import plb_pkg::*;

  localparam int ITEMS_TARGET = 1650;
  localparam int OP_MAX       = (1 << OP_W) - 1;
  localparam int HOLD_AT      = 300;
  localparam int LONG_HOLD    = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int END_SETTLE   = 10;
  localparam int FILL_W       = IN_DATA_W - ACT_W - 3 * TIME_W - COUNT_W;
  localparam int RES_W        = $bits(plb_res_t);

  typedef logic [TIME_W-1:0]  ticks_t;
  typedef logic [COUNT_W-1:0] count_t;

  // input transaction payload, first field in the lowest bits
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    count_t            blink_count;
    ticks_t            inactive_ticks;
    ticks_t            active_ticks;
    ticks_t            delay_ticks;
    act_t              action;
  } cmd_t;

  // tracks the output sequence and holds the levels still owed by the block
  class pin_level_scoreboard;
    bit     polarity_high = 1'b1;
    bit     lvl;
    bit     saved_lvl;
    act_t   next_act;
    mode_t  mode;
    ticks_t delay_left;
    ticks_t tick_cnt;
    ticks_t active_len;
    ticks_t inactive_len;
    count_t periods_left;
    bit     endless;
    bit     first_step;
    bit     in_active;
    bit     idle = 1'b1;
    plb_res_t levels_due[$];
    int     errors;
    int     checked;

    function void arm(mode_t m, act_t a, ticks_t dly, ticks_t al, ticks_t il, count_t cnt);
      tick_cnt     = '0;
      mode         = m;
      next_act     = a;
      delay_left   = dly;
      active_len   = al;
      inactive_len = il;
      endless      = (cnt == '0);
      periods_left = cnt;
      first_step   = 1'b1;
      in_active    = 1'b1;
      idle         = 1'b0;
    endfunction

    function void do_act();
      case (next_act)
        ACT_RESET:  lvl = 1'b0;
        ACT_SET:    lvl = 1'b1;
        ACT_TOGGLE: lvl = ~lvl;
        default:    ;
      endcase
    endfunction

    // go back to the remembered static level on the next tick
    function void arm_return();
      arm(MODE_STATIC, saved_lvl ? ACT_SET : ACT_RESET, '0, '0, '0, '0);
    endfunction

    function void settle();
      do_act();
      saved_lvl = lvl;
      idle      = 1'b1;
    endfunction

    // one tick: delay first, then the active and inactive phases
    function void advance();
      bit flip;
      flip = 1'b0;
      if (idle) return;
      if (tick_cnt != '1) tick_cnt++;
      if (delay_left != '0 && tick_cnt <= delay_left) return;
      delay_left = '0;
      case (mode)
        MODE_PULSE: begin
          if (first_step) begin
            do_act();
            first_step = 1'b0;
            tick_cnt   = '0;
          end
          if (tick_cnt > active_len) begin
            arm_return();
            settle();
          end
        end
        MODE_BLINK: begin
          if (first_step) begin
            do_act();
            next_act   = ACT_TOGGLE;
            first_step = 1'b0;
            tick_cnt   = '0;
          end
          if (in_active && tick_cnt > active_len) begin
            flip = 1'b1;
          end else if (!in_active && tick_cnt > inactive_len) begin
            // a finite train ends after its last inactive phase
            if (!endless) begin
              periods_left--;
              if (periods_left == '0) begin
                arm_return();
                settle();
                return;
              end
            end
            flip = 1'b1;
          end
          if (flip) begin
            do_act();
            in_active = ~in_active;
            tick_cnt  = '0;
          end
        end
        MODE_STATIC: settle();
        default:     ;
      endcase
    endfunction

    // note an accepted input transaction and queue the levels it gives
    function void take_command(logic [OP_W-1:0] op, cmd_t c);
      plb_res_t r;
      bit       bad;
      bad = 1'b0;
      case (op)
        OP_TICK: advance();
        OP_SET, OP_PULSE, OP_BLINK: begin
          if (c.action == ACT_INVALID) begin
            bad = 1'b1;
          end else if (op == OP_SET) begin
            arm(MODE_STATIC, c.action, c.delay_ticks, '0, '0, '0);
          end else if (op == OP_PULSE) begin
            arm(MODE_PULSE, c.action, c.delay_ticks, c.active_ticks, '0, '0);
          end else begin
            arm(MODE_BLINK, c.action, c.delay_ticks, c.active_ticks, c.inactive_ticks,
                c.blink_count);
          end
        end
        OP_ABORT: if (!idle) arm_return();
        default:  ;
      endcase
      r.pin_level   = lvl ^ ~polarity_high;
      r.logic_level = lvl;
      r.busy_res    = ~idle;
      r.status      = bad;
      levels_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [OUT_DATA_W-1:0] want,
                                logic [OUT_DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // check one result transaction against the oldest expectation
    function void check_levels(logic [OUT_DATA_W-1:0] d);
      plb_res_t got;
      plb_res_t want;
      got = plb_res_t'(d[RES_W-1:0]);
      checked++;
      if (levels_due.size() == 0) begin
        $error("result %0h with nothing expected", d);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      compare_field("pin_level", want.pin_level, got.pin_level);
      compare_field("logic_level", want.logic_level, got.logic_level);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("status", want.status, got.status);
      compare_field("zero fill", '0, d[OUT_DATA_W-1:RES_W]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  pin_level_scoreboard sb = new();
  int sent;
  int burst_left;

  logic_pulse_blink_output dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_levels(out_tdata);
  end

  // stop when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("** logic_pulse_blink_output: FAILED **");
    $finish;
  end

  // receiver: segments of steady, random and periodic stalls, one long hold-off
  initial begin : result_sink
    int seg_len;
    int style;
    int k;
    bit held_off;
    held_off = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && sent >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_off = 1'b1;
      end
      seg_len = $urandom_range(10, 80);
      style   = $urandom_range(0, 3);
      k       = $urandom_range(2, 4);
      for (int i = 0; i < seg_len; i++) begin
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= (i % k == 0);
          default: out_tready <= (i % k != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic cmd_t make_cmd(act_t a, ticks_t dly, ticks_t al, ticks_t il, count_t cnt);
    cmd_t c;
    c                = '0;
    c.action         = a;
    c.delay_ticks    = dly;
    c.active_ticks   = al;
    c.inactive_ticks = il;
    c.blink_count    = cnt;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    return make_cmd(act_t'($urandom_range(ACT_RESET, ACT_INVALID)), $urandom, $urandom,
                    $urandom, $urandom);
  endfunction

  // mostly short times, now and then a full-range or all-ones value
  function automatic ticks_t pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 90) return $urandom_range(4, 12);
    if (r < 96) return $urandom;
    return '1;
  endfunction

  function automatic count_t pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom;
  endfunction

  // offer one transaction, wait for it to be taken, then maybe pause
  task automatic push_item(input logic [OP_W-1:0] op, input cmd_t cmd);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.take_command(op, cmd);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) push_item(OP_TICK, random_cmd());
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.checked < sent) @(posedge clk);
  endtask

  task automatic write_polarity(input bit high);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= high;
    @(posedge clk);
    sb.polarity_high = high;
    cfg_wr_en <= 1'b0;
  endtask

  // directed: every operation, extremes and the special cases
  task automatic run_directed();
    cmd_t c;
    // tick and abort while idle
    send_ticks(1);
    push_item(OP_ABORT, random_cmd());
    // static set right away, then a delayed toggle
    push_item(OP_SET, make_cmd(ACT_SET, '0, '0, '0, '0));
    send_ticks(1);
    push_item(OP_SET, make_cmd(ACT_TOGGLE, 2, '0, '0, '0));
    send_ticks(3);
    // invalid action is rejected
    c        = make_cmd(ACT_INVALID, '1, '1, '1, '1);
    c.action = ACT_INVALID;
    push_item(OP_SET, c);
    // single pulse, then return to the remembered level
    push_item(OP_PULSE, make_cmd(ACT_SET, '0, 1, '0, '0));
    send_ticks(3);
    // finite blink train with a delay
    push_item(OP_BLINK, make_cmd(ACT_TOGGLE, 1, '0, '0, 1));
    send_ticks(4);
    // endless blink stopped by abort
    push_item(OP_BLINK, make_cmd(ACT_SET, '0, '0, '0, '0));
    send_ticks(1);
    push_item(OP_ABORT, random_cmd());
    send_ticks(1);
    // all-ones delay never ends until abort
    push_item(OP_BLINK, make_cmd(ACT_RESET, '1, '1, '1, '1));
    send_ticks(1);
    push_item(OP_ABORT, random_cmd());
    send_ticks(1);
    // unknown opcodes
    for (int u = OP_ABORT + 1; u <= OP_MAX; u++) push_item(u, random_cmd());
  endtask

  // random: mostly a start command followed by ticks, the rest noise
  task automatic run_scenario();
    int pick;
    int n;
    int cut;
    logic [OP_W-1:0] op;
    cmd_t c;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      case ($urandom_range(0, 3))
        0:       op = OP_SET;
        1:       op = OP_PULSE;
        default: op = OP_BLINK;
      endcase
      push_item(op, make_cmd(act_t'($urandom_range(ACT_RESET, ACT_TOGGLE)), pick_time(),
                             pick_time(), pick_time(), pick_count()));
      n   = $urandom_range(0, 30);
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == cut) push_item(OP_ABORT, random_cmd());
        push_item(OP_TICK, random_cmd());
      end
    end else if (pick < 88) begin
      push_item(OP_ABORT, random_cmd());
      send_ticks($urandom_range(0, 3));
    end else if (pick < 94) begin
      c        = random_cmd();
      c.action = ACT_INVALID;
      push_item($urandom_range(OP_SET, OP_BLINK), c);
    end else begin
      push_item($urandom_range(OP_ABORT + 1, OP_MAX), random_cmd());
    end
  endtask

  // reset, then four phases alternating the polarity
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      write_polarity(ph % 2 == 0);
      if (ph == 0) run_directed();
      while (sent < ITEMS_TARGET * (ph + 1) / 4) run_scenario();
      drain();
    end
    repeat (END_SETTLE) @(posedge clk);
    if (sb.levels_due.size() != 0) $error("%0d results never arrived", sb.levels_due.size());
    if (sb.errors == 0 && sb.levels_due.size() == 0)
      $display("** logic_pulse_blink_output: PASSED **");
    else
      $display("** logic_pulse_blink_output: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
rtl/plb_pkg.sv
rtl/plb_core.sv
rtl/plb_out.sv
rtl/logic_pulse_blink_output.sv
test/tb_logic_pulse_blink_output.sv
